@@ hdl/ddoi_pkg.sv @@
// shared types, constants and tables for the differential drive odometry integrator
package ddoi_pkg;

   localparam int ERPM_W = 21;
   localparam int DT_W   = 20;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SEP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND    = 2'd2;

   localparam logic [1:0] FUNC_LEFT  = 2'd0;
   localparam logic [1:0] FUNC_RIGHT = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic [31:0] INV_4PI_Q32 = 32'd341782638;
   localparam logic [15:0] DEADBAND_RST = 16'd3277;

   // one queued job between front and back
   typedef struct packed {
      logic [1:0]              func;
      logic signed [ERPM_W-1:0] speed_erpm;
      logic [DT_W-1:0]         elapsed_time;
   } job_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        heading;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] linear_speed;
      logic signed [31:0] angular_rate;
   } result_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;    5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
            5'd20: r = 32'd652;        5'd21: r = 32'd326;
            5'd22: r = 32'd163;        5'd23: r = 32'd81;
            5'd24: r = 32'd41;         5'd25: r = 32'd20;
            5'd26: r = 32'd10;         5'd27: r = 32'd5;
            5'd28: r = 32'd3;          5'd29: r = 32'd1;
            5'd30: r = 32'd1;          default: r = 32'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      begin
         if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
         else if (v < -66'sd2147483648) r = 32'sh80000000;
         else r = v[31:0];
         return r;
      end
   endfunction

endpackage

@@ hdl/diff_drive_odometry_integrator.sv @@
// Differential drive odometry integrator. A wheel report is handled in the back
// end's wheel state; a tick takes two passes of the single shared CORDIC iteration
// unit with the multiply sequencer between them.
// A two-entry queue lets new items be accepted while a tick is processed and
// while a result waits in the output register.
module diff_drive_odometry_integrator #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // speed_erpm[20:0], elapsed_time[40:21], zero pad
   input  logic [1:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // pos_x, pos_y, heading, quat_z, quat_w, linear_speed, angular_rate
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   logic [31:0] scale_ff;
   logic [23:0] isep_ff;
   logic [15:0] db_ff;
   logic job_valid, job_take;
   ddoi_pkg::job_type job;
   ddoi_pkg::result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
         isep_ff <= '0;
         db_ff <= ddoi_pkg::DEADBAND_RST;
      end else if (csr_we) begin
         case (csr_index)
            ddoi_pkg::CSR_SPEED_SCALE: scale_ff <= csr_wdata;
            ddoi_pkg::CSR_INV_SEP:     isep_ff <= csr_wdata[23:0];
            ddoi_pkg::CSR_DEADBAND:    db_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   ddoi_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_func(req_tuser), .req_erpm(req_tdata[20:0]), .req_dt(req_tdata[40:21]),
      .job_valid(job_valid), .job_take(job_take), .job(job)
   );

   ddoi_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_take(job_take), .job(job),
      .speed_scale(scale_ff), .inv_sep(isep_ff), .deadband(db_ff),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(res)
   );

   assign rsp_tdata = {res.angular_rate, res.linear_speed, res.quat_w, res.quat_z,
                       res.heading, res.pos_y, res.pos_x};
endmodule

@@ hdl/ddoi_front.sv @@
// input side: accepts items, drops unknown kinds, queues jobs
module ddoi_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_func,
   input  logic [ddoi_pkg::ERPM_W-1:0] req_erpm,
   input  logic [ddoi_pkg::DT_W-1:0]   req_dt,
   output logic                job_valid,
   input  logic                job_take,
   output ddoi_pkg::job_type   job
);
   localparam int PW = (ddoi_pkg::QUEUE_DEPTH > 1) ? $clog2(ddoi_pkg::QUEUE_DEPTH) : 1;

   ddoi_pkg::job_type q_ff [ddoi_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic push, pop, known;

   assign known = (req_func == ddoi_pkg::FUNC_LEFT) || (req_func == ddoi_pkg::FUNC_RIGHT) ||
                  (req_func == ddoi_pkg::FUNC_TICK);
   assign req_tready = (cnt_ff != (PW+1)'(ddoi_pkg::QUEUE_DEPTH));
   assign push = req_tvalid && req_tready && known;
   assign pop  = job_valid && job_take;
   assign job_valid = (cnt_ff != '0);
   assign job = q_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push) wp_in = (wp_ff == PW'(ddoi_pkg::QUEUE_DEPTH-1)) ? '0 : wp_ff + 1'b1;
      if (pop)  rp_in = (rp_ff == PW'(ddoi_pkg::QUEUE_DEPTH-1)) ? '0 : rp_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= '{func: req_func, speed_erpm: req_erpm, elapsed_time: req_dt};
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(ddoi_pkg::QUEUE_DEPTH)) else $error("queue overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> !pop) else $error("pop of empty queue");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
`endif
endmodule

@@ hdl/ddoi_back.sv @@
// execution side: wheel scaling, yaw rate, cordic and pose integration
module ddoi_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_take,
   input  ddoi_pkg::job_type   job,
   input  logic [31:0]         speed_scale,
   input  logic [23:0]         inv_sep,
   input  logic [15:0]         deadband,
   output logic                res_valid,
   input  logic                res_ready,
   output ddoi_pkg::result_type res
);
   localparam int SW = $clog2(CORDIC_STEPS + 1);
   localparam int DT_W_L = ddoi_pkg::DT_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_WHEEL, ST_TICK0, ST_C1, ST_MUL1, ST_MUL2, ST_YAW, ST_C2, ST_OUT
   } state_type;

   state_type state_ff;
   logic signed [31:0] left_ff, right_ff, x_ff, y_ff, lin_ff, ang_ff;
   logic [31:0] yaw_ff;
   logic [DT_W_L-1:0] dt_ff;
   logic wsel_ff;
   logic signed [ddoi_pkg::ERPM_W-1:0] erpm_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic [1:0] quad_ff;
   logic [SW-1:0] it_ff;
   logic signed [63:0] p_ff, q_ff;
   logic [1:0] mstep_ff;

   // cordic step
   logic signed [33:0] dx, dy;
   logic [4:0] idx;
   assign idx = 5'(it_ff);
   assign dx = cy_ff >>> idx;
   assign dy = cx_ff >>> idx;

   // rotated outputs
   logic signed [33:0] cos_v, sin_v;
   always_comb begin
      case (quad_ff)
         2'd0: begin cos_v = cx_ff; sin_v = cy_ff; end
         2'd1: begin cos_v = -cy_ff; sin_v = cx_ff; end
         2'd2: begin cos_v = -cx_ff; sin_v = -cy_ff; end
         default: begin cos_v = cy_ff; sin_v = -cx_ff; end
      endcase
   end

   function automatic logic signed [15:0] q15(input logic signed [33:0] v);
      logic signed [34:0] t;
      begin
         t = (35'(v) + 35'sd16384) >>> 15;
         if (t > 35'sd32767) return 16'sh7FFF;
         if (t < -35'sd32768) return 16'sh8000;
         return t[15:0];
      end
   endfunction

   logic [31:0] cph;
   logic [1:0]  cq;
   logic [31:0] crest;
   assign cq = 2'((cph + 32'h20000000) >> 30);
   assign crest = cph - {cq, 30'd0};

   logic signed [63:0] wprod;
   logic signed [31:0] wspd;
   logic [31:0] wmag;
   assign wprod = 64'(erpm_ff) * $signed({32'd0, speed_scale});
   assign wspd = ddoi_pkg::sat32(66'((wprod + 64'sd32768) >>> 16));
   assign wmag = wspd[31] ? -wspd : wspd;

   logic signed [63:0] ang_prod;
   assign ang_prod = 64'(64'(right_ff) - 64'(left_ff)) * $signed({40'd0, inv_sep});

   // velocity fits in 33 bits
   logic signed [32:0] pv;
   assign pv = p_ff[32:0];

   logic pneg;
   logic [63:0] pmag;
   logic [63:0] dpart;
   assign pneg = p_ff[63];
   assign pmag = pneg ? 64'(-p_ff) : 64'(p_ff);

   // cordic phase: doubled old yaw for the step, new yaw for the quaternion
   always_comb begin
      dpart = 64'(pmag[63:32]) * 64'(ddoi_pkg::INV_4PI_Q32)
            + ((64'(pmag[31:0]) * 64'(ddoi_pkg::INV_4PI_Q32)) >> 32);
      if (state_ff == ST_YAW) cph = yaw_ff + (pneg ? -dpart[31:0] : dpart[31:0]);
      else cph = {yaw_ff[30:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff <= '0;
         right_ff <= '0;
         x_ff <= '0;
         y_ff <= '0;
         yaw_ff <= '0;
         it_ff <= '0;
         res_valid <= 1'b0;
         job_take <= 1'b0;
      end else begin
         job_take <= (state_ff == ST_IDLE) && job_valid && !job_take;
         if (res_valid && res_ready) res_valid <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (job_valid && !job_take) begin
                  erpm_ff <= job.speed_erpm;
                  dt_ff <= job.elapsed_time;
                  wsel_ff <= (job.func == ddoi_pkg::FUNC_RIGHT);
                  state_ff <= (job.func == ddoi_pkg::FUNC_TICK) ? ST_TICK0 : ST_WHEEL;
               end
            end
            ST_WHEEL: begin
               if (wmag < {16'd0, deadband}) begin
                  if (wsel_ff) right_ff <= '0; else left_ff <= '0;
               end else begin
                  if (wsel_ff) right_ff <= wspd; else left_ff <= wspd;
               end
               state_ff <= ST_IDLE;
            end
            ST_TICK0: begin
               if (!res_valid) begin
                  lin_ff <= 32'((33'(left_ff) + 33'(right_ff)) >>> 1);
                  ang_ff <= ddoi_pkg::sat32(66'((ang_prod + 64'sd32768) >>> 16));
                  quad_ff <= cq;
                  cx_ff <= ddoi_pkg::GAIN_Q30;
                  cy_ff <= '0;
                  cz_ff <= 34'(signed'(crest));
                  it_ff <= '0;
                  state_ff <= ST_C1;
               end
            end
            ST_C1, ST_C2: begin
               if (it_ff == SW'(CORDIC_STEPS)) begin
                  if (state_ff == ST_C1) begin
                     mstep_ff <= '0;
                     state_ff <= ST_MUL1;
                  end else state_ff <= ST_OUT;
               end else begin
                  if (!cz_ff[33]) begin
                     cx_ff <= cx_ff - dx; cy_ff <= cy_ff + dy;
                     cz_ff <= cz_ff - 34'(ddoi_pkg::atan_entry(idx));
                  end else begin
                     cx_ff <= cx_ff + dx; cy_ff <= cy_ff - dy;
                     cz_ff <= cz_ff + 34'(ddoi_pkg::atan_entry(idx));
                  end
                  it_ff <= it_ff + 1'b1;
               end
            end
            ST_MUL1: begin
               // velocity then step, x then y
               case (mstep_ff)
                  2'd0: p_ff <= (64'(lin_ff) * 64'(cos_v) + 64'sd536870912) >>> 30;
                  2'd1: begin
                     q_ff <= (64'(pv) * $signed({44'd0, dt_ff}) + 64'sd32768) >>> 16;
                  end
                  2'd2: p_ff <= (64'(lin_ff) * 64'(sin_v) + 64'sd536870912) >>> 30;
                  default: q_ff <= (64'(pv) * $signed({44'd0, dt_ff}) + 64'sd32768) >>> 16;
               endcase
               if (mstep_ff == 2'd2)
                  x_ff <= ddoi_pkg::sat32(66'(x_ff) + 66'(q_ff));
               mstep_ff <= mstep_ff + 1'b1;
               if (mstep_ff == 2'd3) state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               y_ff <= ddoi_pkg::sat32(66'(y_ff) + 66'(q_ff));
               p_ff <= 64'(ang_ff) * $signed({44'd0, dt_ff});
               state_ff <= ST_YAW;
            end
            ST_YAW: begin
               yaw_ff <= cph;
               quad_ff <= cq;
               cx_ff <= ddoi_pkg::GAIN_Q30;
               cy_ff <= '0;
               cz_ff <= 34'(signed'(crest));
               it_ff <= '0;
               state_ff <= ST_C2;
            end
            ST_OUT: begin
               res.pos_x <= x_ff;
               res.pos_y <= y_ff;
               res.heading <= yaw_ff;
               res.quat_z <= q15(sin_v);
               res.quat_w <= q15(cos_v);
               res.linear_speed <= lin_ff;
               res.angular_rate <= ang_ff;
               res_valid <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |-> $past(state_ff) == ST_IDLE) else $error("take outside idle");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> res_valid) else $error("result not shown");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      it_ff <= SW'(CORDIC_STEPS)) else $error("cordic overrun");
`endif
endmodule

@@ bench/diff_drive_odometry_integrator_tb.sv @@
// self-checking testbench for the differential drive odometry integrator
`timescale 1ns / 100ps

module diff_drive_odometry_integrator_tb;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE = 100;
   localparam int ROWS = 20;
   localparam int SPLIT = 6;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [191:0] rsp_tdata;
   logic         csr_we = 0;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   diff_drive_odometry_integrator uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // odometry predictor state
   logic [31:0] scale_reg = 0;
   logic [23:0] inv_sep_reg = 0;
   logic [15:0] deadband_reg = ddoi_pkg::DEADBAND_RST;
   longint left_v = 0, right_v = 0, x_pos = 0, y_pos = 0;
   logic [31:0] yaw = 0;

   const longint ATAN[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861};

   ddoi_pkg::result_type pose_q[$];
   int errors = 0;
   bit calm = 0;
   int cycles = 0;

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clip16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic void rotate(input logic [31:0] ph, output longint c, output longint s);
      logic [31:0] quad, rest;
      longint x, y, z, dx, dy;
      quad = (ph + 32'h20000000) >> 30;
      rest = ph - (quad << 30);
      z = longint'(signed'(rest));
      x = longint'(ddoi_pkg::GAIN_Q30);
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN[i];
         end else begin
            x += dx; y -= dy; z += ATAN[i];
         end
      end
      case (quad[1:0])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint wheel_mps(input logic signed [20:0] erpm);
      longint v, m;
      v = clip32((longint'(erpm) * longint'(scale_reg) + 32768) >>> 16);
      m = v < 0 ? -v : v;
      if (m < longint'(deadband_reg)) v = 0;
      return v;
   endfunction

   function automatic ddoi_pkg::result_type integrate_tick(input logic [19:0] dt_raw);
      ddoi_pkg::result_type r;
      longint dt, lin, ang, c, s, vel, p;
      logic [63:0] mag, d;
      logic [31:0] d32;
      bit neg;
      dt = longint'(dt_raw);
      lin = (left_v + right_v) >>> 1;
      ang = clip32(((right_v - left_v) * longint'(inv_sep_reg) + 32768) >>> 16);
      rotate({yaw[30:0], 1'b0}, c, s);
      vel = (lin * c + (64'sd1 <<< 29)) >>> 30;
      x_pos = clip32(x_pos + ((vel * dt + 32768) >>> 16));
      vel = (lin * s + (64'sd1 <<< 29)) >>> 30;
      y_pos = clip32(y_pos + ((vel * dt + 32768) >>> 16));
      p = ang * dt;
      neg = p < 0;
      mag = neg ? -p : p;
      d = (mag >> 32) * 64'(ddoi_pkg::INV_4PI_Q32)
        + (((mag & 64'hFFFFFFFF) * 64'(ddoi_pkg::INV_4PI_Q32)) >> 32);
      d32 = d[31:0];
      if (neg) d32 = 32'd0 - d32;
      yaw = yaw + d32;
      rotate(yaw, c, s);
      r.pos_x = x_pos[31:0];
      r.pos_y = y_pos[31:0];
      r.heading = yaw;
      r.quat_z = 16'(clip16((s + (64'sd1 <<< 14)) >>> 15));
      r.quat_w = 16'(clip16((c + (64'sd1 <<< 14)) >>> 15));
      r.linear_speed = lin[31:0];
      r.angular_rate = ang[31:0];
      return r;
   endfunction

   task automatic send(input logic [1:0] func, input logic signed [20:0] erpm,
                       input logic [19:0] dt, input bit typed,
                       input ddoi_pkg::result_type typed_res);
      ddoi_pkg::result_type r;
      if (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 0;
         while ($urandom_range(99) < 18) @(posedge clock);
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= func;
      req_tdata <= {7'b0, dt, erpm};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      case (func)
         ddoi_pkg::FUNC_LEFT: left_v = wheel_mps(erpm);
         ddoi_pkg::FUNC_RIGHT: right_v = wheel_mps(erpm);
         ddoi_pkg::FUNC_TICK: begin
            r = integrate_tick(dt);
            pose_q.push_back(typed ? typed_res : r);
         end
         default: ;
      endcase
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         ddoi_pkg::CSR_SPEED_SCALE: scale_reg = val;
         ddoi_pkg::CSR_INV_SEP: inv_sep_reg = val[23:0];
         ddoi_pkg::CSR_DEADBAND: deadband_reg = val[15:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (pose_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic setup(input logic [31:0] sc, input logic [23:0] inv, input logic [15:0] db);
      drain();
      write_csr(ddoi_pkg::CSR_SPEED_SCALE, sc);
      write_csr(ddoi_pkg::CSR_INV_SEP, {8'b0, inv});
      write_csr(ddoi_pkg::CSR_DEADBAND, {16'b0, db});
      csr_we <= 0;
   endtask

   task automatic cmp(input string nm, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t %s mismatch: expected %h actual %h", $time, nm, e, a);
      end
   endtask

   always @(posedge clock) begin
      ddoi_pkg::result_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[111:96],
                rsp_tdata[127:112], rsp_tdata[159:128], rsp_tdata[191:160]};
         if (pose_q.size() == 0) begin
            errors++;
            $display("%0t unexpected transfer: expected none actual %h", $time, got);
         end else begin
            want = pose_q.pop_front();
            cmp("pos_x", want.pos_x, got.pos_x);
            cmp("pos_y", want.pos_y, got.pos_y);
            cmp("heading", want.heading, got.heading);
            cmp("quat_z", {16'b0, want.quat_z}, {16'b0, got.quat_z});
            cmp("quat_w", {16'b0, want.quat_w}, {16'b0, got.quat_w});
            cmp("linear_speed", want.linear_speed, got.linear_speed);
            cmp("angular_rate", want.angular_rate, got.angular_rate);
         end
      end
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   typedef struct {
      logic [1:0] func;
      logic signed [20:0] erpm;
      logic [19:0] dt;
      bit typed;
   } row_type;

   row_type rows [ROWS] = '{
      '{ddoi_pkg::FUNC_TICK, 21'sd0, 20'd0, 1},
      '{ddoi_pkg::FUNC_LEFT, 21'sh100000, 20'd0, 0},
      '{ddoi_pkg::FUNC_RIGHT, 21'sd1048575, 20'hFFFFF, 0},
      '{ddoi_pkg::FUNC_TICK, 21'sd0, 20'hFFFFF, 1},
      '{FUNC_NONE, 21'sd1048575, 20'hFFFFF, 0},
      '{ddoi_pkg::FUNC_TICK, 21'sd0, 20'd1311, 1},
      '{ddoi_pkg::FUNC_LEFT, 21'sd1000, 20'd0, 0},
      '{ddoi_pkg::FUNC_RIGHT, 21'sd3000, 20'd0, 0},
      '{ddoi_pkg::FUNC_TICK, 21'sd0, 20'd1311, 0},
      '{ddoi_pkg::FUNC_TICK, 21'sd0, 20'hFFFFF, 0},
      '{ddoi_pkg::FUNC_LEFT, 21'sd1, 20'd0, 0},
      '{ddoi_pkg::FUNC_TICK, 21'sd0, 20'd0, 0},
      '{FUNC_NONE, -21'sd5, 20'd7, 0},
      '{ddoi_pkg::FUNC_LEFT, 21'sh100000, 20'd0, 0},
      '{ddoi_pkg::FUNC_RIGHT, 21'sd1048575, 20'd0, 0},
      '{ddoi_pkg::FUNC_TICK, 21'sd0, 20'hFFFFF, 0},
      '{ddoi_pkg::FUNC_RIGHT, 21'sh100000, 20'd0, 0},
      '{ddoi_pkg::FUNC_TICK, 21'sd0, 20'hFFFFF, 0},
      '{ddoi_pkg::FUNC_LEFT, 21'sd1048575, 20'd0, 0},
      '{ddoi_pkg::FUNC_TICK, 21'sd0, 20'h7FFFF, 0}
   };

   logic [31:0] cfg_scale [6] = '{32'h00100000, 32'hFFFFFFFF, 32'h0, 32'h0,
                                  32'h00010000, 32'h00400000};
   logic [23:0] cfg_inv [6] = '{24'h010000, 24'hFFFFFF, 24'h0, 24'h0, 24'h004000, 24'h030000};
   logic [15:0] cfg_db [6] = '{16'd3277, 16'hFFFF, 16'h0, 16'h0, 16'd100, 16'h0};

   initial begin
      ddoi_pkg::result_type at_rest;
      logic [1:0] f;
      logic signed [20:0] e;
      logic [19:0] t;
      int k;
      // cordic residual at zero yaw leaves sine just below minus half an lsb
      at_rest = '{pos_x: 0, pos_y: 0, heading: 0, quat_z: -16'sd1, quat_w: 16'sh7FFF,
                  linear_speed: 0, angular_rate: 0};
      cfg_scale[3] = $urandom;
      cfg_inv[3] = 24'($urandom);
      cfg_db[3] = 16'($urandom);
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < ROWS; i++) begin
         if (i == SPLIT) setup(32'h00100000, 24'h010000, 16'd3277);
         send(rows[i].func, rows[i].erpm, rows[i].dt, rows[i].typed, at_rest);
      end
      for (int ph = 0; ph < 6; ph++) begin
         setup(cfg_scale[ph], cfg_inv[ph], cfg_db[ph]);
         calm = (ph == 2);
         for (int n = 0; n < 230; n++) begin
            k = $urandom_range(99);
            f = k < 32 ? ddoi_pkg::FUNC_LEFT : k < 64 ? ddoi_pkg::FUNC_RIGHT :
                k < 95 ? ddoi_pkg::FUNC_TICK : FUNC_NONE;
            if ($urandom_range(9) == 0) e = 21'($urandom);
            else e = 21'($signed($urandom_range(40000)) - 20000);
            if ($urandom_range(4) == 0) t = 20'($urandom);
            else t = 20'($urandom_range(1400));
            send(f, e, t, 0, at_rest);
         end
         calm = 0;
      end
      drain();
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/ddoi_pkg.sv
hdl/ddoi_front.sv
hdl/ddoi_back.sv
hdl/diff_drive_odometry_integrator.sv
bench/diff_drive_odometry_integrator_tb.sv
